### rtl/core/lls_pkg.sv
// Package for the least loaded server assigner: field widths, reset values
// and the small control structs passed along the cell row. No dependencies.
package lls_pkg;

    localparam int LOAD_W    = 40;
    localparam int DUR_W     = 16;
    localparam int SRV_W     = 5;
    localparam int CFG_W     = 5;
    localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;
    localparam logic [LOAD_W-1:0] LOAD_MAX = {LOAD_W{1'b1}};

    typedef struct packed {
        logic valid;
        logic best_ok;
        logic sec_ok;
    } lls_wave_t;

    typedef struct packed {
        logic clear;
        logic en;
    } lls_wr_t;

endpackage

### rtl/core/lls_if.sv
// Handshake interfaces for job beats in and result beats out.
// Depends on lls_pkg for field widths.
interface lls_job_if import lls_pkg::*;;
    logic             valid;
    logic             ready;
    logic             start_case;
    logic [DUR_W-1:0] job_duration;

    modport source (output valid, output start_case, output job_duration, input ready);
    modport sink   (input valid, input start_case, input job_duration, output ready);
endinterface

interface lls_res_if import lls_pkg::*;;
    logic             valid;
    logic             ready;
    logic [SRV_W-1:0] assigned_server;
    logic [SRV_W-1:0] next_server;

    modport source (output valid, output assigned_server, output next_server, input ready);
    modport sink   (input valid, input assigned_server, input next_server, output ready);
endinterface

### rtl/core/lls_cell.sv
// One server cell: holds that server's load total and folds it into the
// running best / second-best wave passed to the next cell. Uses lls_pkg.
module lls_cell
    import lls_pkg::*;
#(
    parameter int IDX_W    = 4,
    parameter int CELL_IDX = 0
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              active,
    input  lls_wr_t           wr,
    input  logic [IDX_W-1:0]  wr_idx,
    input  logic [LOAD_W-1:0] wr_val,
    input  lls_wave_t         wave_in,
    input  logic [LOAD_W-1:0] best_val_in,
    input  logic [IDX_W-1:0]  best_idx_in,
    input  logic [LOAD_W-1:0] sec_val_in,
    input  logic [IDX_W-1:0]  sec_idx_in,
    output lls_wave_t         wave_out,
    output logic [LOAD_W-1:0] best_val_out,
    output logic [IDX_W-1:0]  best_idx_out,
    output logic [LOAD_W-1:0] sec_val_out,
    output logic [IDX_W-1:0]  sec_idx_out
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    logic [LOAD_W-1:0] load_reg;
    logic [LOAD_W-1:0] load_next;

    lls_wave_t         wave_reg;
    lls_wave_t         wave_next;
    logic [LOAD_W-1:0] best_val_reg, best_val_next;
    logic [IDX_W-1:0]  best_idx_reg, best_idx_next;
    logic [LOAD_W-1:0] sec_val_reg, sec_val_next;
    logic [IDX_W-1:0]  sec_idx_reg, sec_idx_next;

    always_comb
    begin
        load_next = load_reg;
        if (wr.clear)
        begin
            load_next = '0;
        end
        else if (wr.en && (wr_idx == MY_IDX))
        begin
            load_next = wr_val;
        end
    end

    always_comb
    begin
        wave_next     = wave_in;
        best_val_next = best_val_in;
        best_idx_next = best_idx_in;
        sec_val_next  = sec_val_in;
        sec_idx_next  = sec_idx_in;
        if (wave_in.valid && active)
        begin
            if (!wave_in.best_ok)
            begin
                wave_next.best_ok = 1'b1;
                best_val_next     = load_reg;
                best_idx_next     = MY_IDX;
            end
            else if (load_reg < best_val_in)
            begin
                wave_next.sec_ok = 1'b1;
                sec_val_next     = best_val_in;
                sec_idx_next     = best_idx_in;
                best_val_next    = load_reg;
                best_idx_next    = MY_IDX;
            end
            else if (!wave_in.sec_ok || (load_reg < sec_val_in))
            begin
                wave_next.sec_ok = 1'b1;
                sec_val_next     = load_reg;
                sec_idx_next     = MY_IDX;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_reg <= '0;
            wave_reg <= '0;
        end
        else
        begin
            load_reg <= load_next;
            wave_reg <= wave_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_val_reg <= best_val_next;
        best_idx_reg <= best_idx_next;
        sec_val_reg  <= sec_val_next;
        sec_idx_reg  <= sec_idx_next;
    end

    assign wave_out     = wave_reg;
    assign best_val_out = best_val_reg;
    assign best_idx_out = best_idx_reg;
    assign sec_val_out  = sec_val_reg;
    assign sec_idx_out  = sec_idx_reg;

endmodule

### rtl/core/least_loaded_server_assigner_unit.sv
// Top level of the least loaded server assigner: cell row plus dispatch control.
// Depends on lls_pkg, lls_if (lls_job_if, lls_res_if) and lls_cell.
//
// Usage:
//   job beats (start_case, job_duration) enter on the job channel, one result
//   beat (assigned_server, next_server) per job leaves on the res channel.
//   cfg_we / cfg_wdata write active_servers; write it only while no job is in
//   flight. A value of 0 acts as 1, values above MAX_SERVERS act as MAX_SERVERS.
//   Each job sends one scan wave down the row of MAX_SERVERS cells, one cell
//   per cycle; the last cell's wave gives the least and second least loaded
//   servers, from which the update and next_server are formed.
//   The job beat is registered as the wave seed, crosses the cell registers,
//   then the holding and output registers before the result beat is offered.
//   A new job is taken only once the scan ends and the holding register is empty.
//   A finished result sits in the output register while the next job is taken;
//   if the receiver stalls longer, a second result waits in a holding register
//   and job ready stays low until it moves on.
//   Reset: all totals clear to zero, active_servers returns to 16, both
//   channels go empty.
module least_loaded_server_assigner_unit
    import lls_pkg::*;
#(
    parameter int MAX_SERVERS = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_wdata,
    lls_job_if.sink          job,
    lls_res_if.source        res
);

    localparam int IDX_W = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
    localparam int CNT_W = ($clog2(MAX_SERVERS + 1) > CFG_W) ? $clog2(MAX_SERVERS + 1) : CFG_W;
    localparam int NUM_W = (IDX_W > SRV_W) ? IDX_W : SRV_W;

    logic [CFG_W-1:0] active_reg;
    logic             scanning_reg;
    logic             seed_reg;
    logic [DUR_W-1:0] dur_reg;
    logic             hold_valid_reg;
    logic [SRV_W-1:0] hold_assigned_reg;
    logic [SRV_W-1:0] hold_next_reg;
    logic             out_valid_reg;
    logic [SRV_W-1:0] out_assigned_reg;
    logic [SRV_W-1:0] out_next_reg;

    logic [MAX_SERVERS-1:0] active_vec;
    lls_wave_t              wave     [0:MAX_SERVERS];
    logic [LOAD_W-1:0]      best_val [0:MAX_SERVERS];
    logic [IDX_W-1:0]       best_idx [0:MAX_SERVERS];
    logic [LOAD_W-1:0]      sec_val  [0:MAX_SERVERS];
    logic [IDX_W-1:0]       sec_idx  [0:MAX_SERVERS];

    lls_wr_t           wr;
    logic              accept;
    logic              done;
    logic              move;
    logic [LOAD_W:0]   sum_wide;
    logic [LOAD_W-1:0] new_load;
    logic [IDX_W-1:0]  pick;
    logic [IDX_W-1:0]  next_idx;
    logic [NUM_W-1:0]  pick_num;
    logic [NUM_W-1:0]  next_num;

    assign accept = job.valid && job.ready;
    assign job.ready = !scanning_reg && !hold_valid_reg;
    assign done = wave[MAX_SERVERS].valid;
    assign move = hold_valid_reg && (!out_valid_reg || res.ready);

    assign wave[0]     = '{valid: seed_reg, best_ok: 1'b0, sec_ok: 1'b0};
    assign best_val[0] = '0;
    assign best_idx[0] = '0;
    assign sec_val[0]  = '0;
    assign sec_idx[0]  = '0;

    genvar g;
    generate
        for (g = 0; g < MAX_SERVERS; g++)
        begin : g_cell
            assign active_vec[g] = (g == 0) || (CNT_W'(active_reg) > CNT_W'(g));

            lls_cell #(
                .IDX_W    (IDX_W),
                .CELL_IDX (g)
            ) u_cell (
                .clk          (clk),
                .rst_n        (rst_n),
                .active       (active_vec[g]),
                .wr           (wr),
                .wr_idx       (pick),
                .wr_val       (new_load),
                .wave_in      (wave[g]),
                .best_val_in  (best_val[g]),
                .best_idx_in  (best_idx[g]),
                .sec_val_in   (sec_val[g]),
                .sec_idx_in   (sec_idx[g]),
                .wave_out     (wave[g+1]),
                .best_val_out (best_val[g+1]),
                .best_idx_out (best_idx[g+1]),
                .sec_val_out  (sec_val[g+1]),
                .sec_idx_out  (sec_idx[g+1])
            );
        end
    endgenerate

    always_comb
    begin
        pick     = best_idx[MAX_SERVERS];
        sum_wide = {1'b0, best_val[MAX_SERVERS]} + {{(LOAD_W+1-DUR_W){1'b0}}, dur_reg};
        new_load = sum_wide[LOAD_W] ? LOAD_MAX : sum_wide[LOAD_W-1:0];
        next_idx = pick;
        if (wave[MAX_SERVERS].sec_ok)
        begin
            if (sec_val[MAX_SERVERS] < new_load)
            begin
                next_idx = sec_idx[MAX_SERVERS];
            end
            else if ((sec_val[MAX_SERVERS] == new_load) && (sec_idx[MAX_SERVERS] < pick))
            begin
                next_idx = sec_idx[MAX_SERVERS];
            end
        end
        pick_num = NUM_W'(pick) + NUM_W'(1);
        next_num = NUM_W'(next_idx) + NUM_W'(1);
        wr.clear = accept && job.start_case;
        wr.en    = done;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg     <= CFG_RESET;
            scanning_reg   <= 1'b0;
            seed_reg       <= 1'b0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                active_reg <= cfg_wdata;
            end
            seed_reg <= accept;
            if (accept)
            begin
                scanning_reg <= 1'b1;
            end
            else if (done)
            begin
                scanning_reg <= 1'b0;
            end
            if (done)
            begin
                hold_valid_reg <= 1'b1;
            end
            else if (move)
            begin
                hold_valid_reg <= 1'b0;
            end
            if (move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            dur_reg <= job.job_duration;
        end
        if (done)
        begin
            hold_assigned_reg <= pick_num[SRV_W-1:0];
            hold_next_reg     <= next_num[SRV_W-1:0];
        end
        if (move)
        begin
            out_assigned_reg <= hold_assigned_reg;
            out_next_reg     <= hold_next_reg;
        end
    end

    assign res.valid           = out_valid_reg;
    assign res.assigned_server = out_assigned_reg;
    assign res.next_server     = out_next_reg;

endmodule

### tb/least_loaded_server_assigner_unit_tb.sv
// Self-checking testbench for least_loaded_server_assigner_unit: random and directed job beats,
// an in-bench model of the per-server backlog, and phases of active_servers and handshake stalls.
// Depends on lls_pkg, lls_if (lls_job_if, lls_res_if) and the RTL top level.
module least_loaded_server_assigner_unit_tb;
    import lls_pkg::*;

    localparam int N_SRV      = 16;
    localparam int SETTLE     = 2 * N_SRV + 8;
    localparam int LIMIT      = 600000;
    localparam int PHASE_JOBS = 170;
    localparam int N_PHASES   = 10;

    typedef struct packed {
        logic             start_case;
        logic [DUR_W-1:0] job_duration;
    } job_t;

    typedef struct packed {
        logic [SRV_W-1:0] assigned_server;
        logic [SRV_W-1:0] next_server;
    } route_t;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_wdata;

    lls_job_if job_ch ();
    lls_res_if res_ch ();

    least_loaded_server_assigner_unit #(
        .MAX_SERVERS (N_SRV)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .job       (job_ch),
        .res       (res_ch)
    );

    job_t             pending_jobs[$];
    route_t           expected_routes[$];
    logic [LOAD_W-1:0] backlog [N_SRV];
    logic [CFG_W-1:0] active_cfg;
    int               sender_idle_pct;
    int               receiver_stall_pct;
    int               errors;
    int               cycles;

    function automatic int unsigned servers_in_use();
        int unsigned n;
        n = active_cfg;
        if (n == 0)
            n = 1;
        if (n > N_SRV)
            n = N_SRV;
        return n;
    endfunction

    function automatic int unsigned lightest_server(int unsigned n);
        int unsigned best;
        best = 0;
        for (int unsigned i = 1; i < n; i++)
            if (backlog[i] < backlog[best])
                best = i;
        return best;
    endfunction

    function automatic route_t dispatch_job(job_t j);
        int unsigned       n;
        int unsigned       pick;
        logic [LOAD_W:0]   sum;
        route_t            r;
        n = servers_in_use();
        if (j.start_case)
            for (int i = 0; i < N_SRV; i++)
                backlog[i] = '0;
        pick = lightest_server(n);
        sum = {1'b0, backlog[pick]} + j.job_duration;
        backlog[pick] = sum[LOAD_W] ? LOAD_MAX : sum[LOAD_W-1:0];
        r.assigned_server = SRV_W'(pick + 1);
        r.next_server     = SRV_W'(lightest_server(n) + 1);
        return r;
    endfunction

    function automatic logic [DUR_W-1:0] pick_duration();
        int unsigned m;
        m = $urandom_range(99);
        if (m < 35)
            return DUR_W'($urandom_range(3));
        else if (m < 45)
            return '0;
        else if (m < 55)
            return '1;
        else if (m < 70)
            return DUR_W'($urandom_range(2000, 1000));
        else
            return DUR_W'($urandom);
    endfunction

    task automatic push_job(logic start, logic [DUR_W-1:0] dur);
        job_t j;
        j.start_case   = start;
        j.job_duration = dur;
        pending_jobs.push_back(j);
    endtask

    task automatic queue_random_jobs(int count);
        int   made;
        int   len;
        logic well;
        made = 0;
        while (made < count)
        begin
            well = ($urandom_range(99) < 85);
            len  = $urandom_range(40, 1);
            for (int k = 0; k < len && made < count; k++)
            begin
                push_job(well ? (k == 0) : ($urandom_range(99) < 30), pick_duration());
                made++;
            end
        end
    endtask

    task automatic wait_idle();
        while (pending_jobs.size() != 0 || job_ch.valid || expected_routes.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_active_servers(logic [CFG_W-1:0] v);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        active_cfg = v;
    endtask

    task automatic set_stalls(int phase);
        case (phase % 4)
            0:
            begin
                sender_idle_pct    = 0;
                receiver_stall_pct = 0;
            end
            1:
            begin
                sender_idle_pct    = 60;
                receiver_stall_pct = 0;
            end
            2:
            begin
                sender_idle_pct    = 0;
                receiver_stall_pct = 60;
            end
            default:
            begin
                sender_idle_pct    = 7;
                receiver_stall_pct = 7;
            end
        endcase
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (job_ch.valid && job_ch.ready)
                expected_routes.push_back(dispatch_job({job_ch.start_case, job_ch.job_duration}));
            if (!job_ch.valid || job_ch.ready)
            begin
                if (pending_jobs.size() != 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    job_t j;
                    j = pending_jobs.pop_front();
                    job_ch.valid        <= 1'b1;
                    job_ch.start_case   <= j.start_case;
                    job_ch.job_duration <= j.job_duration;
                end
                else
                    job_ch.valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                if (expected_routes.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result beat, assigned_server %0d next_server %0d",
                             $time, res_ch.assigned_server, res_ch.next_server);
                end
                else
                begin
                    route_t want;
                    want = expected_routes.pop_front();
                    if (res_ch.assigned_server !== want.assigned_server)
                    begin
                        errors++;
                        $display("%0t: assigned_server expected %0d actual %0d",
                                 $time, want.assigned_server, res_ch.assigned_server);
                    end
                    if (res_ch.next_server !== want.next_server)
                    begin
                        errors++;
                        $display("%0t: next_server expected %0d actual %0d",
                                 $time, want.next_server, res_ch.next_server);
                    end
                end
            end
            res_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    initial
    begin
        logic [CFG_W-1:0] phase_cfg [N_PHASES];
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_wdata           = '0;
        job_ch.valid        = 1'b0;
        job_ch.start_case   = 1'b0;
        job_ch.job_duration = '0;
        res_ch.ready        = 1'b0;
        errors              = 0;
        cycles              = 0;
        sender_idle_pct     = 0;
        receiver_stall_pct  = 0;
        active_cfg          = CFG_RESET;
        for (int i = 0; i < N_SRV; i++)
            backlog[i] = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        push_job(1'b1, 16'h0000);
        push_job(1'b0, 16'hFFFF);
        push_job(1'b0, 16'h0001);
        push_job(1'b0, 16'h0000);
        push_job(1'b0, 16'h0000);
        push_job(1'b0, 16'h0000);
        push_job(1'b0, 16'h8000);
        push_job(1'b0, 16'h7FFF);
        push_job(1'b0, 16'hAAAA);
        push_job(1'b0, 16'h5555);
        wait_idle();
        write_active_servers(5'd3);
        push_job(1'b0, 16'd10);
        push_job(1'b0, 16'd20);
        wait_idle();
        write_active_servers(5'd0);
        push_job(1'b0, 16'd4);
        push_job(1'b0, 16'hFFFF);
        wait_idle();
        write_active_servers(5'd31);
        push_job(1'b0, 16'h0000);
        push_job(1'b0, 16'h0001);
        wait_idle();
        write_active_servers(5'd17);
        push_job(1'b1, 16'd100);
        push_job(1'b0, 16'h0000);
        wait_idle();

        phase_cfg = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd2, 5'd17,
                      CFG_W'($urandom_range(15, 3)), 5'd8, CFG_W'($urandom), 5'd16};
        for (int p = 0; p < N_PHASES; p++)
        begin
            write_active_servers(phase_cfg[p]);
            set_stalls(p);
            queue_random_jobs(PHASE_JOBS);
            wait_idle();
        end

        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

### filelist.f
rtl/core/lls_pkg.sv
rtl/core/lls_if.sv
rtl/core/lls_cell.sv
rtl/core/least_loaded_server_assigner_unit.sv
tb/least_loaded_server_assigner_unit_tb.sv
